### hdl/dboc_pkg.sv
// Shared types, constants and register codes for the depth box obstacle counter.
`timescale 1ns / 1ps

package dboc_pkg;

  // Frame geometry limits; pixels at or beyond them are never tested.
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // Field widths.
  localparam int DEPTH_W  = 16;
  localparam int COORD_W  = 10;
  localparam int CENTER_W = 14;
  localparam int IFOC_W   = 24;
  localparam int TRIG_W   = 16;
  localparam int MM_W     = 16;
  localparam int THR_W    = 22;
  localparam int COUNT_W  = 19;
  localparam int LAST_W   = 21;
  localparam int MASK_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Datapath widths.
  localparam int DX_W = 15;   // signed Q.4 offset from the principal point
  localparam int PX_W = 31;   // offset times depth
  localparam int PQ_W = 56;   // lateral / vertical position, 2^-28 mm units
  localparam int PZ_W = 32;   // depth times sine or cosine

  // Queue depths.
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 8;

  localparam logic [PZ_W-1:0]    NEAR_Q     = PZ_W'(100 * 65536);
  localparam logic [MM_W-1:0]    FAR_CAP_MM = MM_W'(800);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [MASK_W-1:0]  MASK_ON    = MASK_W'(255);
  localparam logic [MASK_W-1:0]  MASK_OFF   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X         = 3'd0,
    REG_CENTER_Y         = 3'd1,
    REG_INV_FOCAL_X      = 3'd2,
    REG_INV_FOCAL_Y      = 3'd3,
    REG_TILT_SIN_COS     = 3'd4,
    REG_BOX_LIMITS       = 3'd5,
    REG_DETECT_THRESHOLD = 3'd6,
    REG_INTRINSICS_VALID = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CENTER_W-1:0]     center_x;
    logic [CENTER_W-1:0]     center_y;
    logic [IFOC_W-1:0]       inv_focal_x;
    logic [IFOC_W-1:0]       inv_focal_y;
    logic [TRIG_W-1:0]       tilt_sin;
    logic [TRIG_W-1:0]       tilt_cos;
    logic [MM_W-1:0]         half_width;
    logic [MM_W-1:0]         far_mm;
    logic [MM_W-1:0]         low_mm;
    logic [MM_W-1:0]         height_mm;
    logic signed [THR_W-1:0] threshold;
    logic                    intr_valid;
  } cfg_t;

  // One classified pixel waiting for the back end.
  typedef struct packed {
    logic [DEPTH_W-1:0]     depth;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic                   test;
    logic                   fs;
    logic                   fe;
  } cmd_t;

  // One finished result.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              frame_done;
    logic [LAST_W-1:0] count;
    logic              found;
  } result_t;

endpackage

### hdl/dboc_cfg.sv
// Configuration register file with the far-limit cap.
`timescale 1ns / 1ps

module dboc_cfg
  import dboc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CENTER_W-1:0]     center_x_r, center_y_r;
  logic [IFOC_W-1:0]       inv_focal_x_r, inv_focal_y_r;
  logic [2*TRIG_W-1:0]     tilt_r;
  logic [4*MM_W-1:0]       box_r, box_nxt;
  logic signed [THR_W-1:0] thr_r;
  logic                    intr_valid_r;
  logic                    wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // A far limit above the cap is stored as the cap.
  always_comb begin
    box_nxt = cfg_data;
    if (cfg_data[3*MM_W-1:2*MM_W] > FAR_CAP_MM) begin
      box_nxt[3*MM_W-1:2*MM_W] = FAR_CAP_MM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      inv_focal_x_r <= '0;
      inv_focal_y_r <= '0;
      tilt_r        <= 32'h8000_DDB4;
      box_r         <= 64'h012C_0320_015E_02EE;
      thr_r         <= THR_W'(10000);
      intr_valid_r  <= 1'b0;
    end else if (wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:         center_x_r    <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:         center_y_r    <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:      inv_focal_x_r <= cfg_data[IFOC_W-1:0];
        REG_INV_FOCAL_Y:      inv_focal_y_r <= cfg_data[IFOC_W-1:0];
        REG_TILT_SIN_COS:     tilt_r        <= cfg_data[2*TRIG_W-1:0];
        REG_BOX_LIMITS:       box_r         <= box_nxt;
        REG_DETECT_THRESHOLD: thr_r         <= $signed(cfg_data[THR_W-1:0]);
        REG_INTRINSICS_VALID: intr_valid_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.center_x    = center_x_r;
    cfg.center_y    = center_y_r;
    cfg.inv_focal_x = inv_focal_x_r;
    cfg.inv_focal_y = inv_focal_y_r;
    cfg.tilt_sin    = tilt_r[2*TRIG_W-1:TRIG_W];
    cfg.tilt_cos    = tilt_r[TRIG_W-1:0];
    cfg.half_width  = box_r[4*MM_W-1:3*MM_W];
    cfg.far_mm      = box_r[3*MM_W-1:2*MM_W];
    cfg.low_mm      = box_r[2*MM_W-1:MM_W];
    cfg.height_mm   = box_r[MM_W-1:0];
    cfg.threshold   = thr_r;
    cfg.intr_valid  = intr_valid_r;
  end

endmodule

### hdl/dboc_front.sv
// Front end: accepts pixels, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module dboc_front
  import dboc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic [DEPTH_W-1:0] in_depth_mm,
  input  logic [COORD_W-1:0] in_column,
  input  logic [COORD_W-1:0] in_line,
  input  logic               in_frame_start,
  input  logic               in_frame_end,
  output logic               q_valid,
  output cmd_t               q_item,
  input  logic               q_pop
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  cmd_t             cmd;

  // Only even columns and rows inside the frame limits are tested.
  always_comb begin
    cmd.depth = in_depth_mm;
    cmd.dx    = $signed({1'b0, in_column, 4'b0}) - $signed({1'b0, cfg.center_x});
    cmd.dy    = $signed({1'b0, in_line, 4'b0}) - $signed({1'b0, cfg.center_y});
    cmd.test  = cfg.intr_valid && !in_column[0] && !in_line[0] &&
                (32'(in_column) < MAX_COLS) && (32'(in_line) < MAX_ROWS);
    cmd.fs    = in_frame_start;
    cmd.fe    = in_frame_end;
  end

  assign in_full = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign push    = in_push && !in_full;
  assign pop     = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

### hdl/dboc_back.sv
// Back end: projection pipeline, box test and frame counter.
`timescale 1ns / 1ps

module dboc_back
  import dboc_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_t                                cfg,
  input  logic                                q_valid,
  input  cmd_t                                q_item,
  output logic                                q_pop,
  input  logic [$clog2(OUTQ_DEPTH + 1)-1:0]   oq_level,
  output logic                                res_push,
  output result_t                             res
);

  localparam int LVL_W = $clog2(OUTQ_DEPTH + 1) + 1;

  // Stage valid bits and per-item tags.
  logic v1_r, v2_r, v3_r;
  logic test1_r, fs1_r, fe1_r;
  logic test2_r, fs2_r, fe2_r;
  logic test3_r, fs3_r, fe3_r;

  // Stage 1: offset times depth, depth times sine and cosine.
  logic signed [PX_W-1:0] p_x_nxt, p_x_r, p_y_nxt, p_y_r;
  logic [PZ_W-1:0]        zs_nxt, zs1_r, zq_nxt, zq_r;
  // Stage 2: times inverse focal length, depth window test.
  logic signed [PQ_W-1:0] xq_nxt, xq_r, yq0_nxt, yq0_r;
  logic [PZ_W-1:0]        zs2_r;
  logic                   z_ok_nxt, z_ok2_r;
  // Stage 3: tilt term added, lateral test.
  logic signed [PQ_W-1:0] yq_nxt, yq_r, hw_q;
  logic                   x_ok_nxt, x_ok_r, z_ok3_r;
  // Final: vertical test and counting.
  logic signed [PQ_W-1:0] low_q, hgt_q;
  logic                   y_ok, hit;
  logic [COUNT_W-1:0]     run_r, run_nxt, run_base;
  logic [LAST_W-1:0]      last_r, last_new;

  logic [LVL_W-1:0] busy;

  // Issue only when the result queue has a slot for every item in flight.
  assign busy  = LVL_W'(oq_level) + LVL_W'(v1_r) + LVL_W'(v2_r) + LVL_W'(v3_r);
  assign q_pop = q_valid && (busy < LVL_W'(OUTQ_DEPTH));

  always_comb begin
    p_x_nxt = PX_W'(q_item.dx) * PX_W'($signed({1'b0, q_item.depth}));
    p_y_nxt = PX_W'(q_item.dy) * PX_W'($signed({1'b0, q_item.depth}));
    zs_nxt  = PZ_W'(q_item.depth) * PZ_W'(cfg.tilt_sin);
    zq_nxt  = PZ_W'(q_item.depth) * PZ_W'(cfg.tilt_cos);
  end

  always_comb begin
    xq_nxt   = PQ_W'(p_x_r) * PQ_W'($signed({1'b0, cfg.inv_focal_x}));
    yq0_nxt  = PQ_W'(p_y_r) * PQ_W'($signed({1'b0, cfg.inv_focal_y}));
    z_ok_nxt = !(zq_r < NEAR_Q) && !(zq_r > {cfg.far_mm, 16'b0});
  end

  always_comb begin
    hw_q     = $signed(PQ_W'({cfg.half_width, 28'b0}));
    yq_nxt   = yq0_r + $signed(PQ_W'({zs2_r, 12'b0}));
    x_ok_nxt = !(xq_r > hw_q) && !(xq_r < -hw_q);
  end

  always_comb begin
    low_q    = $signed(PQ_W'({cfg.low_mm, 28'b0}));
    hgt_q    = $signed(PQ_W'({cfg.height_mm, 28'b0}));
    y_ok     = !(yq_r > low_q) && !(yq_r < -hgt_q);
    hit      = test3_r && x_ok_r && z_ok3_r && y_ok;
    run_base = fs3_r ? '0 : run_r;
    run_nxt  = (hit && (run_base != COUNT_MAX)) ? run_base + 1'b1 : run_base;
    last_new = {run_nxt, 2'b00};
  end

  always_comb begin
    res_push       = v3_r;
    res.mask       = hit ? MASK_ON : MASK_OFF;
    res.frame_done = fe3_r;
    res.count      = fe3_r ? last_new : last_r;
    res.found      = fe3_r && !cfg.threshold[THR_W-1] &&
                     ($signed({1'b0, last_new}) > cfg.threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      run_r  <= '0;
      last_r <= '0;
    end else begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        run_r <= run_nxt;
        if (fe3_r) begin
          last_r <= last_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_x_r   <= p_x_nxt;
    p_y_r   <= p_y_nxt;
    zs1_r   <= zs_nxt;
    zq_r    <= zq_nxt;
    test1_r <= q_item.test;
    fs1_r   <= q_item.fs;
    fe1_r   <= q_item.fe;

    xq_r    <= xq_nxt;
    yq0_r   <= yq0_nxt;
    zs2_r   <= zs1_r;
    z_ok2_r <= z_ok_nxt;
    test2_r <= test1_r;
    fs2_r   <= fs1_r;
    fe2_r   <= fe1_r;

    yq_r    <= yq_nxt;
    x_ok_r  <= x_ok_nxt;
    z_ok3_r <= z_ok2_r;
    test3_r <= test2_r;
    fs3_r   <= fs2_r;
    fe3_r   <= fe2_r;
  end

endmodule

### hdl/dboc_out_fifo.sv
// Result queue that feeds the output ports.
`timescale 1ns / 1ps

module dboc_out_fifo
  import dboc_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  result_t                           push_item,
  input  logic                              pop,
  output logic                              empty,
  output result_t                           head,
  output logic [$clog2(OUTQ_DEPTH + 1)-1:0] level
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  result_t          mem_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign level  = cnt_r;
  assign do_pop = pop && !empty;

  // The back end never pushes into a full queue; it reserves slots before issue.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/depth_box_obstacle_counter_core.sv
// Top level of the depth box obstacle counter.
`timescale 1ns / 1ps

//  Channel   Handshake          Transfer when            Carries
//  in_*      in_push / in_full  in_push & !in_full       one depth pixel with tags
//  out_*     out_pop / out_empty out_pop & !out_empty    mask, frame report
//  cfg_*     cfg_valid / ready  cfg_valid & cfg_ready    register index and data
//
// One pixel is taken per cycle as long as results are drained; cfg_ready is always high.
// A pixel passes through the front queue and three pipeline stages (two multiplier
// stages, one add), after which it is written straight into the result queue and shows
// up on the result ports.
// Reset is synchronous and active low; it empties both queues and clears the frame counter.
// When out_pop stays low, the back end stops issuing once the eight-entry result queue
// is spoken for, and in_full rises after the four-entry front queue fills.

module depth_box_obstacle_counter_core
  import dboc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [DEPTH_W-1:0]    in_depth_mm,
  input  logic [COORD_W-1:0]    in_column,
  input  logic [COORD_W-1:0]    in_line,
  input  logic                  in_frame_start,
  input  logic                  in_frame_end,
  // Results
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [MASK_W-1:0]     out_mask_pixel,
  output logic                  out_frame_done,
  output logic [LAST_W-1:0]     out_obstacle_count,
  output logic                  out_obstacle_found,
  // Configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  logic    q_valid, q_pop;
  cmd_t    q_item;
  logic    res_push;
  result_t res, head;
  logic [$clog2(OUTQ_DEPTH + 1)-1:0] oq_level;

  // Register file. Writes are expected only while no pixel is in flight, so the
  // pipeline reads the registers directly.
  dboc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Front end: computes the offsets from the principal point and decides whether
  // the pixel is tested at all, then parks it in a short queue.
  dboc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_depth_mm    (in_depth_mm),
    .in_column      (in_column),
    .in_line        (in_line),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back end: back-projects, tilts, tests against the box and keeps the frame count.
  // It draws from the front queue only when the result queue can take every item
  // already in its pipeline plus this one.
  dboc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .oq_level (oq_level),
    .res_push (res_push),
    .res      (res)
  );

  // Results wait here until the consumer takes them.
  dboc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (head),
    .level     (oq_level)
  );

  assign out_mask_pixel     = head.mask;
  assign out_frame_done     = head.frame_done;
  assign out_obstacle_count = head.count;
  assign out_obstacle_found = head.found;

endmodule

### hdl/dboc_checker.sv
// Port-level assertions for the depth box obstacle counter, bound to the top level.
`timescale 1ns / 1ps

module dboc_checker
  import dboc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [MASK_W-1:0] out_mask_pixel,
  input logic              out_frame_done,
  input logic [LAST_W-1:0] out_obstacle_count,
  input logic              out_obstacle_found
);

  // After reset the result side holds nothing.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A waiting result that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_mask_pixel) &&
    $stable(out_frame_done) && $stable(out_obstacle_count) &&
    $stable(out_obstacle_found)))
    else $error("waiting result changed before transfer");

  // Detection is only reported on the result that closes a frame, with a nonzero count.
  a_found_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_obstacle_found) |-> (out_frame_done && out_obstacle_count != '0))
    else $error("obstacle reported outside a frame report");

  // The mask is either fully on or fully off.
  a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_mask_pixel == MASK_ON || out_mask_pixel == MASK_OFF))
    else $error("mask pixel out of range");

  // The reported count is always a multiple of four, as the hit count is scaled by four.
  a_count_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_obstacle_count[1:0] == 2'b00))
    else $error("obstacle count not a multiple of four");

endmodule

bind depth_box_obstacle_counter_core dboc_checker u_dboc_checker (.*);
